// ===== src/pse_pkg.sv =====
// shared types and constants of the postfix stack evaluator
// no dependencies; used by pse_cell, pse_div and postfix_stack_evaluator_top
package pse_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int LIT_W           = 31;
    localparam int OP_W            = 3;
    localparam int STATUS_W        = 2;
    localparam int DEPTH_OUT_W     = 7;

    // operator selector codes
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB    = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
    localparam logic [OP_W-1:0] OP_UNK    = 3'd5;
    localparam logic [OP_W-1:0] OP_FINISH = 3'd6;
    localparam logic [OP_W-1:0] OP_NONE   = 3'd7;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

    // what each stack cell loads on a clock edge
    typedef enum logic [1:0] {
        CMD_HOLD       = 2'd0,
        CMD_LOAD_UP    = 2'd1,
        CMD_LOAD_NEXT  = 2'd2,
        CMD_LOAD_NEXT2 = 2'd3
    } t_cell_cmd;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } t_state;

endpackage

// ===== src/pse_cell.sv =====
// one stack cell: holds a single word and shifts with its neighbours
// depends on pse_pkg
module pse_cell (
    input  logic                      i_clk,
    input  pse_pkg::t_cell_cmd        i_cmd,
    input  logic [pse_pkg::DATA_W-1:0] i_up,
    input  logic [pse_pkg::DATA_W-1:0] i_next,
    input  logic [pse_pkg::DATA_W-1:0] i_next2,
    output logic [pse_pkg::DATA_W-1:0] o_value
);
    import pse_pkg::*;

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    // select the neighbour to take from
    always_comb begin
        case (i_cmd)
            CMD_LOAD_UP:    n_value = i_up;
            CMD_LOAD_NEXT:  n_value = i_next;
            CMD_LOAD_NEXT2: n_value = i_next2;
            default:        n_value = r_value;
        endcase
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== src/pse_div.sv =====
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on pse_pkg
module pse_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pse_pkg::DATA_W-1:0] i_dividend,
    input  logic [pse_pkg::DATA_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [pse_pkg::DATA_W-1:0] o_quotient
);
    import pse_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_run;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dsr;
    logic              r_neg;

    logic [DATA_W-1:0] w_mag_dvd;
    logic [DATA_W-1:0] w_mag_dsr;
    logic [DATA_W:0]   w_rem_sh;
    logic [DATA_W:0]   w_rem_sub;
    logic              w_fits;

    // operand magnitudes
    assign w_mag_dvd = i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_mag_dsr = i_divisor[DATA_W-1]  ? (~i_divisor + 1'b1)  : i_divisor;

    // one restoring step
    assign w_rem_sh  = {r_rem, r_quo[DATA_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_dsr};
    assign w_fits    = (w_rem_sh >= {1'b0, r_dsr});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_mag_dvd;
            r_dsr <= w_mag_dsr;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_run) begin
            r_rem <= w_fits ? w_rem_sub[DATA_W-1:0] : w_rem_sh[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], w_fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

// ===== src/postfix_stack_evaluator_top.sv =====
// postfix stack evaluator: stack held in a row of shifting cells, top at cell 0
// depends on pse_pkg, pse_cell and pse_div
//
//  channel  | direction | handshake          | fields
//  ---------+-----------+--------------------+-------------------------------------------
//  command  | in        | start, busy        | i_op, i_literal
//  result   | out       | o_valid strobe     | o_top_value, o_status, o_stack_depth,
//           |           |                    | o_is_final
//
// push, add, subtract, multiply, pop and finish are accepted at an edge, with the
// result strobed in the next cycle; busy stays low.
// a divide with two entries and a nonzero divisor runs in the bit-serial divider
// (32 quotient steps plus load and write-back); busy is high while it runs.
// a divide that underflows or divides by zero answers in the next cycle.
// reset clears the stack pointer and sequencer; cell contents are left as they are.
// the receiver cannot stall: each result is held for exactly one cycle.
module postfix_stack_evaluator_top #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pse_pkg::OP_W-1:0]          i_op,
    input  logic [pse_pkg::LIT_W-1:0]         i_literal,
    output logic                              o_valid,
    output logic signed [pse_pkg::DATA_W-1:0] o_top_value,
    output logic [pse_pkg::STATUS_W-1:0]      o_status,
    output logic [pse_pkg::DEPTH_OUT_W-1:0]   o_stack_depth,
    output logic                              o_is_final
);
    import pse_pkg::*;

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int EXT_W = SP_W + DEPTH_OUT_W;

    // cell outputs, padded with two zero words past the bottom
    logic [DATA_W-1:0] w_val [0:STACK_DEPTH+1];
    t_cell_cmd         w_cmd0;
    t_cell_cmd         w_cmd_rest;
    logic [DATA_W-1:0] w_load_val;

    t_state            r_state;
    t_state            n_state;
    logic [SP_W-1:0]   r_sp;
    logic [SP_W-1:0]   n_sp;

    logic              r_valid;
    logic              n_valid;
    logic [DATA_W-1:0] r_top;
    logic [DATA_W-1:0] n_top;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic [DEPTH_OUT_W-1:0] r_depth;
    logic              r_final;
    logic              n_final;

    logic [DATA_W-1:0] w_a;
    logic [DATA_W-1:0] w_b;
    logic [DATA_W-1:0] w_c;
    logic [DATA_W-1:0] w_sum;
    logic [DATA_W-1:0] w_diff;
    logic [DATA_W-1:0] w_prod;
    logic [DATA_W-1:0] w_new_top;
    logic [EXT_W-1:0]  w_sp_ext;
    logic              w_accept;
    logic              w_div_start;
    logic              w_div_done;
    logic [DATA_W-1:0] w_quot;

    assign w_accept = start && !busy;
    assign w_a = w_val[0];
    assign w_b = w_val[1];
    assign w_c = w_val[2];

    // combinational arithmetic on the two top cells
    assign w_sum  = w_a + w_b;
    assign w_diff = w_b - w_a;
    assign w_prod = w_a * w_b;

    // row of stack cells
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic [DATA_W-1:0] w_up;
            t_cell_cmd         w_cmd;
            if (gi == 0) begin : g_head
                assign w_up  = w_load_val;
                assign w_cmd = w_cmd0;
            end else begin : g_body
                assign w_up  = w_val[gi-1];
                assign w_cmd = w_cmd_rest;
            end
            pse_cell u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd),
                .i_up    (w_up),
                .i_next  (w_val[gi+1]),
                .i_next2 (w_val[gi+2]),
                .o_value (w_val[gi])
            );
        end
    endgenerate
    assign w_val[STACK_DEPTH]   = '0;
    assign w_val[STACK_DEPTH+1] = '0;

    // shared iterative divider, b / a
    pse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_b),
        .i_divisor  (w_a),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // decode, stack control and result build
    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        w_cmd0      = CMD_HOLD;
        w_cmd_rest  = CMD_HOLD;
        w_load_val  = w_a;
        n_valid     = 1'b0;
        n_status    = ST_OK;
        n_final     = 1'b0;
        w_div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_valid = 1'b1;
                    case (i_op)
                        OP_PUSH: begin
                            if (r_sp == SP_W'(STACK_DEPTH)) begin
                                n_status = ST_OVER;
                            end else begin
                                w_cmd0     = CMD_LOAD_UP;
                                w_cmd_rest = CMD_LOAD_UP;
                                w_load_val = {1'b0, i_literal};
                                n_sp       = r_sp + 1'b1;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_UNK: begin
                            if (r_sp < SP_W'(2)) begin
                                n_status = ST_UNDER;
                            end else if (i_op == OP_UNK) begin
                                w_cmd0     = CMD_LOAD_NEXT2;
                                w_cmd_rest = CMD_LOAD_NEXT2;
                                n_sp       = r_sp - SP_W'(2);
                            end else if (i_op == OP_DIV) begin
                                if (w_a == '0) begin
                                    n_status = ST_DIVZ;
                                end else begin
                                    n_valid     = 1'b0;
                                    w_div_start = 1'b1;
                                    n_state     = S_DIV;
                                end
                            end else begin
                                w_cmd0     = CMD_LOAD_UP;
                                w_cmd_rest = CMD_LOAD_NEXT;
                                n_sp       = r_sp - 1'b1;
                                case (i_op)
                                    OP_ADD:  w_load_val = w_sum;
                                    OP_SUB:  w_load_val = w_diff;
                                    default: w_load_val = w_prod;
                                endcase
                            end
                        end
                        OP_FINISH: begin
                            if (r_sp == '0) begin
                                n_status = ST_UNDER;
                            end else begin
                                w_cmd0     = CMD_LOAD_NEXT;
                                w_cmd_rest = CMD_LOAD_NEXT;
                                n_sp       = r_sp - 1'b1;
                                n_final    = 1'b1;
                            end
                        end
                        default: begin
                            // selector seven leaves the stack alone
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_cmd0     = CMD_LOAD_UP;
                    w_cmd_rest = CMD_LOAD_NEXT;
                    w_load_val = w_quot;
                    n_sp       = r_sp - 1'b1;
                    n_valid    = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // value that cell 0 takes on this edge
        case (w_cmd0)
            CMD_LOAD_UP:    w_new_top = w_load_val;
            CMD_LOAD_NEXT:  w_new_top = w_b;
            CMD_LOAD_NEXT2: w_new_top = w_c;
            default:        w_new_top = w_a;
        endcase

        if (n_final) begin
            n_top = w_a;
        end else if (n_sp == '0) begin
            n_top = '0;
        end else begin
            n_top = w_new_top;
        end
    end

    assign w_sp_ext = {{DEPTH_OUT_W{1'b0}}, n_sp};

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_valid <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            r_top    <= n_top;
            r_status <= n_status;
            r_depth  <= w_sp_ext[DEPTH_OUT_W-1:0];
            r_final  <= n_final;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_top_value   = r_top;
    assign o_status      = r_status;
    assign o_stack_depth = r_depth;
    assign o_is_final    = r_final;

    // checks
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_no_result_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !r_valid)
        else $error("result strobe while divide in progress");

    a_final_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_final) |-> (r_status == ST_OK))
        else $error("final result with error status");

    a_accept_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_valid || busy))
        else $error("accepted transfer neither answered nor in progress");

endmodule
